[design/wsmf_pkg.sv]
`default_nettype none

package wsmf_pkg;

  localparam int WEIGHT_W         = 8;
  localparam int TARGET_W         = 16;
  localparam int START_W          = 8;
  localparam int OFFSET_W         = 8;
  localparam int LEN_W            = 9;
  localparam int TOTAL_W          = TARGET_W + 1;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int MAX_ELEMENTS_DEF = 256;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);
  localparam logic [START_W-1:0]  START_RESET  = '0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SUM   = 2'd0,
    CFG_START_OFFSET = 2'd1
  } wsmf_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEND,
    S_APPEND,
    S_CHECK,
    S_POP,
    S_EMIT
  } wsmf_state_t;

endpackage

`default_nettype wire

[design/wsmf_ram.sv]
`default_nettype none

module wsmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/window_sum_match_finder.sv]
// flow: a request outside the window range goes from idle straight to emit; otherwise
//   it passes append and check, after a pend drop when a match is left over, with a pop and a check per front drop
// requests: one request at a time; each element in the window range is written to the
//   window ram once and read back once on its drop; emit waits while a result is held
// reset: synchronous active-low rst_n empties the window, sets target_sum to 1 and
//   start_offset to 0; the window ram is not cleared, entries are read only once written
`default_nettype none

module window_sum_match_finder
  import wsmf_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // element requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WEIGHT_W-1:0]   in_element_weight,
  input  logic                  in_last_element,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_match_found,
  output logic [OFFSET_W-1:0]   out_match_offset,
  output logic [LEN_W-1:0]      out_match_length,
  output logic                  out_scan_done
);

  localparam int AW = $clog2(MAX_ELEMENTS);       // window ram address
  localparam int CW = $clog2(MAX_ELEMENTS + 1);   // count and position

  // config registers
  logic [TARGET_W-1:0] target_r;
  logic [START_W-1:0]  start_r;

  // scan state
  wsmf_state_t         state_r, state_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                last_r, last_nxt;
  logic                found_r, found_nxt;
  logic [OFFSET_W-1:0] front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic                pend_r, pend_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic [LEN_W-1:0]    out_length_r, out_length_nxt;
  logic                out_done_r, out_done_nxt;

  // window ram
  logic                ram_we;
  logic [WEIGHT_W-1:0] ram_rdata;

  logic                elem_active;
  logic                out_free;
  logic [TOTAL_W-1:0]  target_ext;

  assign out_free    = !out_valid_r || out_ready;
  assign target_ext  = TOTAL_W'(target_r);
  // element is inside the ram and at or past the start offset
  assign elem_active = (pos_r < CW'(MAX_ELEMENTS)) && (LEN_W'(pos_r) >= LEN_W'(start_r));

  // the read address always follows the front, so the front weight is ready
  // in the cycle after the front pointer settles
  wsmf_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (weight_r),
    .raddr (front_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    weight_nxt     = weight_r;
    last_nxt       = last_r;
    found_nxt      = found_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    pos_nxt        = pos_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    out_length_nxt = out_length_r;
    out_done_nxt   = out_done_r;
    ram_we         = 1'b0;
    in_ready       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          weight_nxt = in_element_weight;
          last_nxt   = in_last_element;
          if (elem_active) begin
            pend_nxt = 1'b0;
            // a match on the previous element drops the front first;
            // the ram read of the front is issued in this cycle
            if (pend_r && (count_r != '0)) begin
              state_nxt = S_PEND;
            end else begin
              state_nxt = S_APPEND;
            end
          end else begin
            found_nxt = 1'b0;
            state_nxt = S_EMIT;
          end
        end
      end

      S_PEND: begin
        total_nxt = total_r - TOTAL_W'(ram_rdata);
        front_nxt = front_r + OFFSET_W'(1);
        count_nxt = count_r - CW'(1);
        state_nxt = S_APPEND;
      end

      S_APPEND: begin
        ram_we = 1'b1;
        if (count_r == '0) begin
          front_nxt = OFFSET_W'(pos_r);
        end
        count_nxt = count_r + CW'(1);
        // one bit of headroom over the target
        total_nxt = total_r + TOTAL_W'(weight_r);
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if ((total_r > target_ext) && (count_r != '0)) begin
          // front read issued here, consumed in the pop state
          state_nxt = S_POP;
        end else begin
          found_nxt = (total_r == target_ext);
          if (total_r == target_ext) begin
            pend_nxt = 1'b1;
          end
          state_nxt = S_EMIT;
        end
      end

      S_POP: begin
        total_nxt = total_r - TOTAL_W'(ram_rdata);
        front_nxt = front_r + OFFSET_W'(1);
        count_nxt = count_r - CW'(1);
        state_nxt = S_CHECK;
      end

      S_EMIT: begin
        // hold here while an earlier result still waits downstream
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_offset_nxt = found_r ? front_r : '0;
          out_length_nxt = found_r ? LEN_W'(count_r) : '0;
          out_done_nxt   = last_r;
          if (pos_r < CW'(MAX_ELEMENTS)) begin
            pos_nxt = pos_r + CW'(1);
          end
          // last element ends the scan
          if (last_r) begin
            front_nxt = '0;
            count_nxt = '0;
            total_nxt = '0;
            pos_nxt   = '0;
            pend_nxt  = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      total_r     <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_RESET;
      start_r     <= START_RESET;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      // unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_SUM:   target_r <= cfg_wdata[TARGET_W-1:0];
          CFG_START_OFFSET: start_r  <= cfg_wdata[START_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    weight_r     <= weight_nxt;
    last_r       <= last_nxt;
    found_r      <= found_nxt;
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
    out_length_r <= out_length_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_found  = out_found_r;
  assign out_match_offset = out_offset_r;
  assign out_match_length = out_length_r;
  assign out_scan_done    = out_done_r;

`ifndef NO_ASSERTIONS
  // an empty window carries no weight
  a_empty_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("window empty but running total nonzero");

  // a pop only consumes a read issued by the check state
  a_pop_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> ($past(state_r) == S_CHECK))
    else $error("pop without preceding front read");

  // window never holds more than the ram depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("window count beyond ram depth");

  // a finished result is presented on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result lost on emit");

  // leaving the check loop the window sum is within the target
  a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHECK) && (state_nxt == S_EMIT)) |-> (total_r <= target_ext))
    else $error("window sum above target at result");
`endif

endmodule

`default_nettype wire
